@@ rtl/suv_pkg.sv @@
// ----------------------------------------------------------------------------
// suv_pkg
// Types and constants shared by the strict UTF-8 stream validator.
// ----------------------------------------------------------------------------
package suv_pkg;

   localparam int OFFSET_WIDTH = 24;
   localparam int OUT_OFFSET_WIDTH = 24;
   localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};

   localparam logic [7:0] CONT_MASK  = 8'hc0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] ASCII_TOP  = 8'h80;
   localparam logic [7:0] LEAD2_LO   = 8'hc2;
   localparam logic [7:0] LEAD2_HI   = 8'hdf;
   localparam logic [7:0] LEAD3_LO   = 8'he0;
   localparam logic [7:0] LEAD3_HI   = 8'hef;
   localparam logic [7:0] LEAD4_LO   = 8'hf0;
   localparam logic [7:0] LEAD4_HI   = 8'hf4;

   localparam logic [20:0] CP3_MIN   = 21'h000800;
   localparam logic [20:0] SURR_LO   = 21'h00d800;
   localparam logic [20:0] SURR_HI   = 21'h00dfff;
   localparam logic [20:0] CP4_MIN   = 21'h010000;
   localparam logic [20:0] CP_MAX    = 21'h10ffff;

   localparam logic [1:0] NEED_2B = 2'd1;
   localparam logic [1:0] NEED_3B = 2'd2;
   localparam logic [1:0] NEED_4B = 2'd3;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_SETTLED = 2'd1,
      ERR_PENDING = 2'd2
   } err_kind_type;

   typedef struct packed {
      logic [1:0]              remaining_cont;
      logic [1:0]              seq_need;
      logic [20:0]             partial_code;
      logic [OFFSET_WIDTH-1:0] lead_offset;
      logic [7:0]              lead_value;
      logic [OFFSET_WIDTH-1:0] byte_count;
      err_kind_type            error_kind;
      logic [OFFSET_WIDTH-1:0] error_offset;
      logic [7:0]              error_value;
   } suv_state_type;

   typedef struct packed {
      logic                        valid_res;
      logic [OUT_OFFSET_WIDTH-1:0] bad_offset;
      logic [7:0]                  bad_byte;
   } suv_result_type;

   localparam suv_state_type STATE_RESET = '{
      remaining_cont: 2'd0,
      seq_need:       2'd0,
      partial_code:   21'd0,
      lead_offset:    '0,
      lead_value:     8'd0,
      byte_count:     '0,
      error_kind:     ERR_NONE,
      error_offset:   '0,
      error_value:    8'd0
   };

endpackage

@@ rtl/suv_decode.sv @@
// ----------------------------------------------------------------------------
// suv_decode
// Per-byte next-state and verdict logic of the UTF-8 validator.
// ----------------------------------------------------------------------------
module suv_decode
   import suv_pkg::*;
(
   input  suv_state_type  cur_state,
   input  logic [7:0]     data_byte,
   input  logic           last,
   output suv_state_type  nxt_state,
   output logic           has_result,
   output suv_result_type result
);

   logic [OFFSET_WIDTH-1:0] off;
   logic                    is_cont;
   logic                    cp_bad;
   suv_state_type           st;

   always_comb begin
      off     = cur_state.byte_count;
      is_cont = (data_byte & CONT_MASK) == CONT_TAG;
      cp_bad  = 1'b0;
      st      = cur_state;

      if (cur_state.error_kind != ERR_SETTLED) begin
         if (cur_state.remaining_cont != 2'd0) begin
            if (!is_cont) begin
               if (cur_state.error_kind == ERR_NONE) begin
                  st.error_kind   = ERR_PENDING;
                  st.error_offset = off;
                  st.error_value  = data_byte;
               end
            end else begin
               st.partial_code = {cur_state.partial_code[14:0], data_byte[5:0]};
            end
            st.remaining_cont = cur_state.remaining_cont - 2'd1;
            if (st.remaining_cont == 2'd0) begin
               if (st.error_kind == ERR_PENDING) begin
                  st.error_kind = ERR_SETTLED;
               end else begin
                  if (cur_state.seq_need == NEED_3B &&
                      (st.partial_code < CP3_MIN ||
                       (st.partial_code >= SURR_LO && st.partial_code <= SURR_HI)))
                     cp_bad = 1'b1;
                  if (cur_state.seq_need == NEED_4B &&
                      (st.partial_code < CP4_MIN || st.partial_code > CP_MAX))
                     cp_bad = 1'b1;
                  if (cp_bad) begin
                     st.error_kind   = ERR_SETTLED;
                     st.error_offset = cur_state.lead_offset;
                     st.error_value  = cur_state.lead_value;
                  end
               end
               st.seq_need = 2'd0;
            end
         end else if (data_byte >= ASCII_TOP) begin
            // open a sequence, or fail at a byte that cannot lead
            if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
               st.seq_need       = NEED_2B;
               st.remaining_cont = NEED_2B;
               st.partial_code   = {16'd0, data_byte[4:0]};
               st.lead_offset    = off;
               st.lead_value     = data_byte;
            end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
               st.seq_need       = NEED_3B;
               st.remaining_cont = NEED_3B;
               st.partial_code   = {17'd0, data_byte[3:0]};
               st.lead_offset    = off;
               st.lead_value     = data_byte;
            end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
               st.seq_need       = NEED_4B;
               st.remaining_cont = NEED_4B;
               st.partial_code   = {18'd0, data_byte[2:0]};
               st.lead_offset    = off;
               st.lead_value     = data_byte;
            end else begin
               st.error_kind   = ERR_SETTLED;
               st.error_offset = off;
               st.error_value  = data_byte;
            end
         end
      end

      if (cur_state.byte_count != OFFSET_MAX)
         st.byte_count = cur_state.byte_count + 1'b1;

      // truncated sequence fails at its lead
      if (last && st.error_kind != ERR_SETTLED && st.remaining_cont != 2'd0) begin
         st.error_kind   = ERR_SETTLED;
         st.error_offset = st.lead_offset;
         st.error_value  = st.lead_value;
      end
   end

   always_comb begin
      has_result = last;
      if (st.error_kind == ERR_SETTLED) begin
         result.valid_res  = 1'b0;
         result.bad_offset = OUT_OFFSET_WIDTH'(st.error_offset);
         result.bad_byte   = st.error_value;
      end else begin
         result.valid_res  = 1'b1;
         result.bad_offset = '0;
         result.bad_byte   = 8'd0;
      end
   end

   // the final byte resets the state; otherwise keep the raw update (byte count only once settled)
   always_comb begin
      if (last) begin
         nxt_state = STATE_RESET;
      end else begin
         nxt_state = cur_state;
         nxt_state.byte_count = st.byte_count;
         if (cur_state.error_kind != ERR_SETTLED) begin
            nxt_state = st;
            nxt_state.byte_count = st.byte_count;
         end
      end
   end

endmodule

@@ rtl/strict_utf8_stream_validator_unit.sv @@
// ----------------------------------------------------------------------------
// strict_utf8_stream_validator_unit
// Checks a byte stream as strict UTF-8 and reports a verdict on the last byte.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_data_byte, req_last
//  rsp     | out       | rsp_valid/rsp_stall | rsp_valid_res, rsp_bad_offset,
//          |           |                     | rsp_bad_byte
//
// One byte per cycle while req_stall is low; verdicts are registered.
// The state registers and a two-entry result buffer (output register plus
// skid register) set the timing; req_stall is a registered skid-full flag.
// Synchronous active-high reset clears state and empties the result buffer.
// Requests flow on while one verdict waits for rsp_stall; a second waiting
// verdict fills the skid register and stalls every request until it drains.
// ----------------------------------------------------------------------------
module strict_utf8_stream_validator_unit
   import suv_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_valid_res,
   output logic [OUT_OFFSET_WIDTH-1:0] rsp_bad_offset,
   output logic [7:0]                  rsp_bad_byte
);

   suv_state_type  state_ff, state_in, step_state;
   suv_result_type out_ff, out_in, skid_ff, skid_in, step_res;
   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   logic           step_has_res;
   logic           accept, push, out_free;

   suv_decode u_decode (
      .cur_state  (state_ff),
      .data_byte  (req_data_byte),
      .last       (req_last),
      .nxt_state  (step_state),
      .has_result (step_has_res),
      .result     (step_res)
   );

   assign accept   = req_valid && !req_stall;
   assign push     = accept && step_has_res;
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = accept ? step_state : state_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // drain skid first to keep order
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_in       = step_res;
            skid_valid_in = push;
         end else begin
            out_in        = step_res;
            out_valid_in  = push;
         end
      end else if (push) begin
         skid_in       = step_res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall      = skid_valid_ff;
   assign rsp_valid      = out_valid_ff;
   assign rsp_valid_res  = out_ff.valid_res;
   assign rsp_bad_offset = out_ff.bad_offset;
   assign rsp_bad_byte   = out_ff.bad_byte;

endmodule

@@ rtl/suv_checker.sv @@
// ----------------------------------------------------------------------------
// suv_checker
// Port-level checks for the strict UTF-8 stream validator.
// ----------------------------------------------------------------------------
module suv_checker
   import suv_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_last,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_valid_res,
   input logic [OUT_OFFSET_WIDTH-1:0] rsp_bad_offset,
   input logic [7:0]                  rsp_bad_byte
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_valid_res) &&
      $stable(rsp_bad_offset) && $stable(rsp_bad_byte))
      else $error("stalled response changed");

   a_valid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_bad_offset == '0 && rsp_bad_byte == 8'd0)
      else $error("valid verdict carries a failure location");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("request stall without a blocked response");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last && !rsp_valid |=> rsp_valid)
      else $error("final byte produced no verdict");

endmodule

bind strict_utf8_stream_validator_unit suv_checker u_suv_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_last       (req_last),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_valid_res  (rsp_valid_res),
   .rsp_bad_offset (rsp_bad_offset),
   .rsp_bad_byte   (rsp_bad_byte)
);

@@ verif/utf8_verdict_checker.sv @@
// ----------------------------------------------------------------------------
// utf8_verdict_checker
// Watches both channels of the UTF-8 validator, scans every accepted byte with
// its own strict UTF-8 decoder, and compares each verdict against the oldest
// verdict it predicted. Mismatches and unexpected verdicts are counted.
// ----------------------------------------------------------------------------
module utf8_verdict_checker
   import suv_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_last,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic                        rsp_valid_res,
   input  logic [OUT_OFFSET_WIDTH-1:0] rsp_bad_offset,
   input  logic [7:0]                  rsp_bad_byte,
   output int                          fault_count,
   output int                          open_verdicts
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OFFSET_WIDTH-1:0] POS_TOP = {OFFSET_WIDTH{1'b1}};
   localparam logic [7:0]  TWO_FIRST   = 8'hc2;
   localparam logic [7:0]  TWO_LAST    = 8'hdf;
   localparam logic [7:0]  THREE_FIRST = 8'he0;
   localparam logic [7:0]  THREE_LAST  = 8'hef;
   localparam logic [7:0]  FOUR_FIRST  = 8'hf0;
   localparam logic [7:0]  FOUR_LAST   = 8'hf4;
   localparam logic [20:0] MIN_3B      = 21'h000800;
   localparam logic [20:0] SURR_FIRST  = 21'h00d800;
   localparam logic [20:0] SURR_LAST   = 21'h00dfff;
   localparam logic [20:0] MIN_4B      = 21'h010000;
   localparam logic [20:0] MAX_CODE    = 21'h10ffff;

   logic [1:0]              cont_left;
   logic [1:0]              seq_len;
   logic [20:0]             code_acc;
   logic [OFFSET_WIDTH-1:0] byte_pos;
   logic [OFFSET_WIDTH-1:0] lead_pos;
   logic [OFFSET_WIDTH-1:0] fault_pos;
   logic [7:0]              lead_byte;
   logic [7:0]              fault_byte;
   err_kind_type            fault_state;
   suv_result_type          verdict_q[$];

   initial begin
      fault_count = 0;
      open_verdicts = 0;
   end

   task automatic log_mismatch(input string what);
      $display("%0t ns: verdict mismatch: %s", $time, what);
      fault_count++;
   endtask

   task automatic clear_scan();
      cont_left = '0;
      seq_len = '0;
      code_acc = '0;
      byte_pos = '0;
      lead_pos = '0;
      fault_pos = '0;
      lead_byte = '0;
      fault_byte = '0;
      fault_state = ERR_NONE;
   endtask

   task automatic mark_fault(input logic [OFFSET_WIDTH-1:0] pos, input logic [7:0] b);
      fault_state = ERR_SETTLED;
      fault_pos = pos;
      fault_byte = b;
   endtask

   task automatic open_sequence(input logic [1:0] need, input logic [20:0] bits,
                                input logic [OFFSET_WIDTH-1:0] pos, input logic [7:0] b);
      seq_len = need;
      cont_left = need;
      code_acc = bits;
      lead_pos = pos;
      lead_byte = b;
   endtask

   task automatic scan_byte(input logic [7:0] b, input logic fin);
      logic [OFFSET_WIDTH-1:0] pos;
      suv_result_type          verdict;
      pos = byte_pos;
      if (fault_state != ERR_SETTLED) begin
         if (cont_left != 2'd0) begin
            if (b[7:6] != 2'b10) begin
               // hold the mismatch until the sequence's full length is in
               if (fault_state == ERR_NONE) begin
                  fault_state = ERR_PENDING;
                  fault_pos = pos;
                  fault_byte = b;
               end
            end else begin
               code_acc = {code_acc[14:0], b[5:0]};
            end
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
               if (fault_state == ERR_PENDING)
                  fault_state = ERR_SETTLED;
               else if ((seq_len == NEED_3B && (code_acc < MIN_3B ||
                         (code_acc >= SURR_FIRST && code_acc <= SURR_LAST))) ||
                        (seq_len == NEED_4B && (code_acc < MIN_4B || code_acc > MAX_CODE)))
                  mark_fault(lead_pos, lead_byte);
               seq_len = 2'd0;
            end
         end else if (b[7]) begin
            if (b >= TWO_FIRST && b <= TWO_LAST)
               open_sequence(NEED_2B, {16'd0, b[4:0]}, pos, b);
            else if (b >= THREE_FIRST && b <= THREE_LAST)
               open_sequence(NEED_3B, {17'd0, b[3:0]}, pos, b);
            else if (b >= FOUR_FIRST && b <= FOUR_LAST)
               open_sequence(NEED_4B, {18'd0, b[2:0]}, pos, b);
            else
               mark_fault(pos, b);
         end
      end
      if (byte_pos != POS_TOP)
         byte_pos = byte_pos + 1'b1;
      if (fin) begin
         // a text cut short fails at its lead, over any pending mismatch
         if (fault_state != ERR_SETTLED && cont_left != 2'd0)
            mark_fault(lead_pos, lead_byte);
         if (fault_state == ERR_SETTLED) begin
            verdict.valid_res = 1'b0;
            verdict.bad_offset = OUT_OFFSET_WIDTH'(fault_pos);
            verdict.bad_byte = fault_byte;
         end else begin
            verdict.valid_res = 1'b1;
            verdict.bad_offset = '0;
            verdict.bad_byte = '0;
         end
         verdict_q.push_back(verdict);
         clear_scan();
      end
   endtask

   always @(posedge clock) begin
      suv_result_type want;
      if (reset) begin
         clear_scan();
         verdict_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               log_mismatch($sformatf("unexpected verdict %0b/%0h/%0h",
                                      rsp_valid_res, rsp_bad_offset, rsp_bad_byte));
            end else begin
               want = verdict_q.pop_front();
               if (rsp_valid_res !== want.valid_res || rsp_bad_offset !== want.bad_offset ||
                   rsp_bad_byte !== want.bad_byte)
                  log_mismatch($sformatf("got %0b/%0h/%0h, want %0b/%0h/%0h",
                                         rsp_valid_res, rsp_bad_offset, rsp_bad_byte,
                                         want.valid_res, want.bad_offset, want.bad_byte));
            end
         end
         if (req_valid && !req_stall)
            scan_byte(req_data_byte, req_last);
      end
      open_verdicts <= verdict_q.size();
   end

endmodule

@@ verif/strict_utf8_stream_validator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// strict_utf8_stream_validator_unit_tb
// Feeds texts to the strict UTF-8 validator: a handful of hand-picked texts
// covering boundaries and failure kinds, then random texts built mostly from
// well-formed sequences mixed with overlong, surrogate, out-of-range, noise
// and broken sequences. Both channels idle at random; a checker predicts and
// compares every verdict.
// ----------------------------------------------------------------------------
module strict_utf8_stream_validator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import suv_pkg::*;

   localparam int TEXT_BYTES = 1800;
   localparam int HUSH_LIMIT = 2000;
   localparam logic [20:0] EDGE_CODES [10] = '{
      21'h00007f, 21'h0007ff, 21'h000800, 21'h00d7ff, 21'h00d800,
      21'h00dfff, 21'h00e000, 21'h00ffff, 21'h10ffff, 21'h110000
   };

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [7:0]                  req_data_byte = 8'h00;
   logic                        req_last = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_valid_res;
   logic [OUT_OFFSET_WIDTH-1:0] rsp_bad_offset;
   logic [7:0]                  rsp_bad_byte;
   int                          fault_count;
   int                          open_verdicts;
   logic                        calm = 1'b0;
   int                          bytes_sent = 0;
   logic [7:0]                  text_q[$];

   strict_utf8_stream_validator_unit dut (.*);

   utf8_verdict_checker verdict_check (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic hold_off();
      return !calm && ($urandom_range(99) < 14);
   endfunction

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= hold_off();
   end

   task automatic push_byte(input logic [7:0] b, input logic fin);
      while (hold_off()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last <= fin;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++)
         push_byte(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   task automatic append_code(input logic [20:0] cp, input int len);
      case (len)
         1: text_q.push_back({1'b0, cp[6:0]});
         2: begin
            text_q.push_back({3'b110, cp[10:6]});
            text_q.push_back({2'b10, cp[5:0]});
         end
         3: begin
            text_q.push_back({4'b1110, cp[15:12]});
            text_q.push_back({2'b10, cp[11:6]});
            text_q.push_back({2'b10, cp[5:0]});
         end
         default: begin
            text_q.push_back({5'b11110, cp[20:18]});
            text_q.push_back({2'b10, cp[17:12]});
            text_q.push_back({2'b10, cp[11:6]});
            text_q.push_back({2'b10, cp[5:0]});
         end
      endcase
   endtask

   task automatic build_random_text();
      int          k;
      int          len;
      int          start;
      logic [20:0] cp;
      repeat ($urandom_range(1, 10)) begin
         k = $urandom_range(99);
         if (k < 30) begin
            append_code(21'($urandom_range(0, 127)), 1);
         end else if (k < 50) begin
            append_code(21'($urandom_range(12'h080, 12'h7ff)), 2);
         end else if (k < 65) begin
            cp = $urandom_range(1) ? 21'($urandom_range(16'h0800, 16'hd7ff))
                                   : 21'($urandom_range(16'he000, 16'hffff));
            append_code(cp, 3);
         end else if (k < 78) begin
            append_code(21'($urandom_range(21'h10000, 21'h10ffff)), 4);
         end else if (k < 84) begin
            // overlong, surrogate, out of range, and boundary code points
            case ($urandom_range(7))
               0: begin cp = 21'($urandom_range(0, 127));                   len = 2; end
               1: begin cp = 21'($urandom_range(0, 12'h7ff));               len = 3; end
               2: begin cp = 21'($urandom_range(16'hd800, 16'hdfff));       len = 3; end
               3: begin cp = 21'($urandom_range(0, 16'hffff));              len = 4; end
               4: begin cp = 21'($urandom_range(21'h110000, 21'h1fffff));   len = 4; end
               default: begin
                  cp = EDGE_CODES[$urandom_range(9)];
                  len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
               end
            endcase
            append_code(cp, len);
         end else if (k < 92) begin
            text_q.push_back(8'($urandom_range(255)));
         end else begin
            // truncate a sequence or corrupt one of its continuation bytes
            len = $urandom_range(2, 4);
            cp = (len == 2) ? 21'($urandom_range(12'h080, 12'h7ff)) :
                 (len == 3) ? 21'($urandom_range(16'he000, 16'hffff)) :
                              21'($urandom_range(21'h10000, 21'h10ffff));
            start = text_q.size();
            append_code(cp, len);
            if ($urandom_range(1))
               repeat ($urandom_range(1, len - 1)) void'(text_q.pop_back());
            else
               text_q[start + $urandom_range(1, len - 1)] = 8'($urandom_range(255));
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      text_q = '{8'h00, 8'h7f};                 send_text();   // ASCII extremes
      text_q = '{8'hc2, 8'h80, 8'hdf, 8'hbf};   send_text();   // two-byte extremes
      text_q = '{8'he0, 8'h80, 8'h80};          send_text();   // overlong three-byte
      text_q = '{8'hed, 8'ha0, 8'h80};          send_text();   // surrogate
      text_q = '{8'hf4, 8'h90, 8'h80, 8'h80};   send_text();   // above the top code point
      text_q = '{8'hff};                        send_text();   // bad lead on the last byte
      text_q = '{8'h41, 8'he1, 8'h41};          send_text();   // truncated over a mismatch
      text_q = '{8'he1, 8'h41, 8'h80, 8'h41};   send_text();   // mismatch, then ignored bytes

      while (bytes_sent < TEXT_BYTES) begin
         calm = (bytes_sent >= 700 && bytes_sent < 1000);
         build_random_text();
         send_text();
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      @(posedge clock);
      while (open_verdicts != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (fault_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // end the run if neither channel moves for too long
   initial begin
      int hush;
      hush = 0;
      while (hush < HUSH_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            hush = 0;
         else
            hush++;
      end
      $display("%0t ns: no progress for %0d cycles", $time, HUSH_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ files.f @@
rtl/suv_pkg.sv
rtl/suv_decode.sv
rtl/strict_utf8_stream_validator_unit.sv
rtl/suv_checker.sv
verif/utf8_verdict_checker.sv
verif/strict_utf8_stream_validator_unit_tb.sv
